/* hdl/assert_macros.svh */
// Assertion helpers included by the allocator core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property sampled at the rising clock edge, ignored while reset is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition on one edge implies a condition on the following edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/sca_pkg.sv */
package sca_pkg;

    localparam int CMD_W    = 3;
    localparam int ORIGIN_W = 16;
    localparam int SOUND_W  = 12;
    localparam int PRIO_W   = 8;
    localparam int CHAN_W   = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_START       = 3'd0,
        CMD_STOP_ORIGIN = 3'd1,
        CMD_RELEASE     = 3'd2,
        CMD_QUERY       = 3'd3,
        CMD_STOP_ALL    = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_GRANTED    = 2'd0,
        ST_NO_CHANNEL = 2'd1,
        ST_STOPPED    = 2'd2,
        ST_NO_MATCH   = 2'd3
    } t_status;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [ORIGIN_W-1:0] origin_tag;
        logic [SOUND_W-1:0]  sfx_id;
        logic [PRIO_W-1:0]   priority_req;
        logic                pickup;
        logic [CHAN_W-1:0]   channel_index;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [CHAN_W-1:0] channel;
        logic              replaced;
        logic              killed_valid;
        logic [CHAN_W-1:0] killed_channel;
        logic              playing;
    } t_rsp;

endpackage

/* hdl/sca_stream_if.sv */
interface sca_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/sca_ram.sv */
module sca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* hdl/sound_channel_allocator_core.sv */
// Sound channel allocator. Each request is a transfer on i_req and gives exactly one
// transfer on o_rsp. One request is worked on at a time: the channel table sits in a
// single RAM that is read one channel per cycle. A request passes the scan and
// drain states, and its response is registered from the done state once the
// previous response has been taken. The next request is taken while a finished
// response still waits on o_rsp. Busy flags live in flops and clear at reset, so
// no table clearing pass is needed.
`include "assert_macros.svh"

module sound_channel_allocator_core #(
    parameter int NUM_CHANNELS  = 8,
    parameter int ORIGIN_BITS   = 16,
    parameter int SOUND_ID_BITS = 12
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_wdata,
    sca_stream_if.sink   i_req,
    sca_stream_if.source o_rsp
);
    localparam int CH_W = NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1;
    localparam int OW   = ORIGIN_BITS < sca_pkg::ORIGIN_W ? ORIGIN_BITS : sca_pkg::ORIGIN_W;
    localparam int SW   = SOUND_ID_BITS < sca_pkg::SOUND_W ? SOUND_ID_BITS : sca_pkg::SOUND_W;
    localparam int PW   = sca_pkg::PRIO_W;
    localparam int ENTRY_W = OW + SW + PW + 1;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_DONE} t_state;

    t_state                       r_state;
    logic                         r_any_kind;
    logic [NUM_CHANNELS-1:0]      r_busy;
    logic [sca_pkg::CMD_W-1:0]    r_cmd;
    logic [OW-1:0]                r_org;
    logic [SW-1:0]                r_snd;
    logic [PW-1:0]                r_pri;
    logic                         r_pk;
    logic [sca_pkg::CHAN_W-1:0]   r_idx;
    logic [CH_W-1:0]              r_rd_idx;
    logic                         r_chk_valid;
    logic [CH_W-1:0]              r_chk_idx;
    logic                         r_kill_found;
    logic [CH_W-1:0]              r_kill_ch;
    logic                         r_pick_found;
    logic [CH_W-1:0]              r_pick_ch;
    logic                         r_pick_rep;
    logic                         r_evict_found;
    logic [CH_W-1:0]              r_evict_ch;
    logic                         r_hit_found;
    logic [CH_W-1:0]              r_hit_ch;
    logic                         r_out_valid;
    sca_pkg::t_rsp                r_out;

    logic [ENTRY_W-1:0]           w_rdata;
    logic [OW-1:0]                w_d_org;
    logic [SW-1:0]                w_d_snd;
    logic [PW-1:0]                w_d_pri;
    logic                         w_d_pk;
    logic                         w_b;
    logic                         w_org_eq;
    logic                         w_kill_m;
    logic                         w_is_kill;
    logic                         w_free;
    logic                         w_reuse;
    logic                         w_pick;
    logic                         w_evict;
    logic                         w_hit_m;
    logic                         w_hit;
    logic                         w_fire;
    logic                         w_grant;
    logic [CH_W-1:0]              w_grant_ch;
    logic                         w_rel_ok;
    sca_pkg::t_rsp                w_rsp;
    logic [NUM_CHANNELS-1:0]      n_busy;

    sca_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_CHANNELS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_fire && w_grant),
        .i_waddr (w_grant_ch),
        .i_wdata ({r_org, r_snd, r_pri, r_pk}),
        .i_re    (r_state == S_SCAN),
        .i_raddr (r_rd_idx),
        .o_rdata (w_rdata)
    );

    // per-channel scan, one table entry per cycle
    assign {w_d_org, w_d_snd, w_d_pri, w_d_pk} = w_rdata;
    assign w_b       = r_busy[r_chk_idx];
    assign w_org_eq  = (w_d_org == r_org);
    assign w_kill_m  = w_b && w_org_eq && (r_any_kind || (w_d_pk == r_pk));
    assign w_is_kill = r_chk_valid && w_kill_m && !r_kill_found;
    assign w_free    = !w_b || w_is_kill;
    assign w_reuse   = (r_org != '0) && w_org_eq && (w_d_pk == r_pk);
    assign w_pick    = r_chk_valid && !r_pick_found && (w_free || w_reuse);
    assign w_evict   = r_chk_valid && !r_evict_found && (w_d_pri >= r_pri);

    always_comb begin
        unique case (r_cmd)
            sca_pkg::CMD_STOP_ORIGIN: w_hit_m = w_b && w_org_eq;
            sca_pkg::CMD_QUERY:       w_hit_m = w_b && w_org_eq && (w_d_snd == r_snd);
            sca_pkg::CMD_STOP_ALL:    w_hit_m = w_b;
            default:                  w_hit_m = 1'b0;
        endcase
    end
    assign w_hit = r_chk_valid && !r_hit_found && w_hit_m;

    assign w_fire   = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);
    assign w_rel_ok = (int'(r_idx) < NUM_CHANNELS) && r_busy[CH_W'(r_idx)];

    // result and table update
    always_comb begin
        w_grant              = 1'b0;
        w_grant_ch           = '0;
        n_busy               = r_busy;
        w_rsp.status         = sca_pkg::ST_NO_MATCH;
        w_rsp.channel        = '0;
        w_rsp.replaced       = 1'b0;
        w_rsp.killed_valid   = 1'b0;
        w_rsp.killed_channel = '0;
        w_rsp.playing        = 1'b0;
        unique case (r_cmd)
            sca_pkg::CMD_START: begin
                if (r_pick_found) begin
                    w_grant        = 1'b1;
                    w_grant_ch     = r_pick_ch;
                    w_rsp.replaced = r_pick_rep;
                end else if (r_evict_found) begin
                    w_grant        = 1'b1;
                    w_grant_ch     = r_evict_ch;
                    w_rsp.replaced = 1'b1;
                end
                w_rsp.killed_valid = r_kill_found;
                if (r_kill_found) begin
                    w_rsp.killed_channel = 3'(r_kill_ch);
                    n_busy[r_kill_ch]    = 1'b0;
                end
                if (w_grant) begin
                    w_rsp.status       = sca_pkg::ST_GRANTED;
                    w_rsp.channel      = 3'(w_grant_ch);
                    n_busy[w_grant_ch] = 1'b1;
                end else begin
                    w_rsp.status = sca_pkg::ST_NO_CHANNEL;
                end
            end
            sca_pkg::CMD_STOP_ORIGIN: begin
                if (r_hit_found) begin
                    w_rsp.status     = sca_pkg::ST_STOPPED;
                    w_rsp.channel    = 3'(r_hit_ch);
                    n_busy[r_hit_ch] = 1'b0;
                end
            end
            sca_pkg::CMD_RELEASE: begin
                if (w_rel_ok) begin
                    w_rsp.status           = sca_pkg::ST_STOPPED;
                    w_rsp.channel          = r_idx;
                    n_busy[CH_W'(r_idx)]   = 1'b0;
                end
            end
            sca_pkg::CMD_QUERY: begin
                if (r_hit_found) begin
                    w_rsp.status  = sca_pkg::ST_GRANTED;
                    w_rsp.channel = 3'(r_hit_ch);
                    w_rsp.playing = 1'b1;
                end
            end
            sca_pkg::CMD_STOP_ALL: begin
                if (r_hit_found) begin
                    w_rsp.status  = sca_pkg::ST_STOPPED;
                    w_rsp.channel = 3'(r_hit_ch);
                    n_busy        = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_any_kind  <= 1'b0;
            r_busy      <= '0;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_any_kind <= i_cfg_wdata;
            end

            r_chk_valid <= (r_state == S_SCAN);
            r_chk_idx   <= r_rd_idx;

            if (w_is_kill) begin
                r_kill_found <= 1'b1;
                r_kill_ch    <= r_chk_idx;
            end
            if (w_pick) begin
                r_pick_found <= 1'b1;
                r_pick_ch    <= r_chk_idx;
                r_pick_rep   <= !w_free;
            end
            if (w_evict) begin
                r_evict_found <= 1'b1;
                r_evict_ch    <= r_chk_idx;
            end
            if (w_hit) begin
                r_hit_found <= 1'b1;
                r_hit_ch    <= r_chk_idx;
            end

            if (w_fire) begin
                r_out_valid <= 1'b1;
                r_out       <= w_rsp;
                r_busy      <= n_busy;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_cmd         <= i_req.payload.command;
                        r_org         <= i_req.payload.origin_tag[OW-1:0];
                        r_snd         <= i_req.payload.sfx_id[SW-1:0];
                        r_pri         <= i_req.payload.priority_req;
                        r_pk          <= i_req.payload.pickup;
                        r_idx         <= i_req.payload.channel_index;
                        r_rd_idx      <= '0;
                        r_kill_found  <= 1'b0;
                        r_kill_ch     <= '0;
                        r_pick_found  <= 1'b0;
                        r_evict_found <= 1'b0;
                        r_hit_found   <= 1'b0;
                        r_state       <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_rd_idx == LAST_CH) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_rd_idx <= r_rd_idx + CH_W'(1);
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_fire) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    `ASSERT_NEXT(a_grant_busy, w_fire && w_grant, r_busy[$past(w_grant_ch)], "granted channel not busy")
    `ASSERT_CLK(a_kill_grants, (w_fire && (r_cmd == sca_pkg::CMD_START) && r_kill_found) |-> w_grant, "kill without grant")
    `ASSERT_NEXT(a_stop_all_clear, w_fire && (r_cmd == sca_pkg::CMD_STOP_ALL), r_busy == '0, "stop all left busy channel")
    `ASSERT_CLK(a_scan_range, (r_state == S_SCAN) |-> (r_rd_idx <= LAST_CH), "scan index out of range")

endmodule
